### src/sus_pkg.sv
// Package for the sort-unique set engine.
// Holds the sequencer state type, the cell control struct and field widths.
// No dependencies.
package sus_pkg;

   // Width of the value fields on the request and response channels
   localparam int FIELD_W = 32;

   // Sequencer states: gather a set, then stream it out
   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;  // place the broadcast value in sorted position
      logic shift;   // move every entry one cell toward the head
   } cell_ctrl_type;

endpackage

### src/sus_cell.sv
// One compare-insert cell of the sorting chain.
// Depends on sus_pkg for the cell control struct.
module sus_cell #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sus_pkg::cell_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      ins_value,
   input  logic                  left_gt,
   input  logic                  left_valid,
   input  logic [WIDTH-1:0]      left_value,
   input  logic                  right_valid,
   input  logic [WIDTH-1:0]      right_value,
   output logic                  valid,
   output logic [WIDTH-1:0]      value,
   output logic                  gt,
   output logic                  eq
);
   import sus_pkg::*;

   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] value_ff, value_in;

   // Compare the held entry against the broadcast value
   assign gt    = !valid_ff || (value_ff > ins_value);
   assign eq    = valid_ff && (value_ff == ins_value);
   assign valid = valid_ff;
   assign value = value_ff;

   // Pick the next entry: take from the left, take the new value, or take from the right
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.insert && gt) begin
         if (left_gt) begin
            valid_in = left_valid;
            value_in = left_value;
         end else begin
            valid_in = 1'b1;
            value_in = ins_value;
         end
      end else if (ctrl.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end
   end

   // Hold the entry; only the valid bit is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

### src/sort_unique_set_engine.sv
// Sort-unique set engine: a chain of DEPTH compare-insert cells keeps the set sorted
// and free of duplicates as requests arrive, one request per cycle while collecting.
// The request that closes a set is inserted in its cycle; results start the next cycle
// and stream out one per cycle from the head cell while rsp_stall is low; requests
// are stalled meanwhile.
// Synchronous reset empties the chain and clears the count and the overflow flag.
module sort_unique_set_engine #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sus_pkg::FIELD_W-1:0]  req_value,
   input  logic                         req_last_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sus_pkg::FIELD_W-1:0]  rsp_sorted_value,
   output logic                         rsp_last_out,
   output logic                         rsp_overflow
);
   import sus_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;

   cell_ctrl_type    ctrl;
   logic [WIDTH-1:0] ins_value;
   logic [DEPTH-1:0] cell_valid, cell_gt, cell_eq;
   logic [WIDTH-1:0] cell_value [DEPTH];

   logic req_acc, rsp_acc, full, dup;

   // Fit the request value to the stored width
   generate
      if (WIDTH <= FIELD_W) begin : g_in_narrow
         assign ins_value = req_value[WIDTH-1:0];
      end else begin : g_in_wide
         assign ins_value = {{(WIDTH - FIELD_W){1'b0}}, req_value};
      end
   endgenerate

   // Handshakes
   assign req_stall = (state_ff == ST_DRAIN);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   // Drop values past the store depth and values already held
   assign full        = (cnt_ff == CW'(DEPTH));
   assign dup         = |cell_eq;
   assign ctrl.insert = req_acc && !full && !dup;
   assign ctrl.shift  = rsp_acc;

   // Build the chain, each cell wired to its neighbors
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic             l_gt, l_valid, r_valid;
         logic [WIDTH-1:0] l_value, r_value;
         if (i == 0) begin : g_head
            assign l_gt    = 1'b0;
            assign l_valid = 1'b0;
            assign l_value = '0;
         end else begin : g_body
            assign l_gt    = cell_gt[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_value = cell_value[i-1];
         end
         if (i == DEPTH - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
         end else begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
         end
         sus_cell #(.WIDTH(WIDTH)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .ins_value   (ins_value),
            .left_gt     (l_gt),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .right_valid (r_valid),
            .right_value (r_value),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .eq          (cell_eq[i])
         );
      end
   endgenerate

   // Present the head cell; it is the last distinct value when its neighbor is empty
   generate
      if (WIDTH <= FIELD_W) begin : g_out_narrow
         assign rsp_sorted_value = FIELD_W'(cell_value[0]);
      end else begin : g_out_wide
         assign rsp_sorted_value = cell_value[0][FIELD_W-1:0];
      end
   endgenerate
   assign rsp_last_out = !cell_valid[1];
   assign rsp_overflow = ovf_ff;

   // Sequence collect and drain, count arrivals, flag overflow
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_acc) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
               if (req_last_in) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_acc && rsp_last_out) begin
               state_in = ST_COLLECT;
               cnt_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   // A drained set always has a value at the head of the chain
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> cell_valid[0])
      else $error("head cell empty while draining");

   // The arrival count never passes the store depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("arrival count beyond depth");

   // The final result returns the block to an empty chain
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_last_out) |=> (state_ff == ST_COLLECT && cell_valid == '0
                                      && cnt_ff == '0 && !ovf_ff))
      else $error("set not cleared after final result");

   // While collecting, distinct entries never outnumber arrivals
   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLLECT) |-> ($countones(cell_valid) <= int'(cnt_ff)))
      else $error("more entries than arrivals");

endmodule
